// ----- rtl/usbpd_snk_pkg.sv -----
// ----------------------------------------------------------------------------
// USB PD sink message engine package
// Shared types, message codes, policy tables and field helpers.
// ----------------------------------------------------------------------------
package usbpd_snk_pkg;

   localparam int MAX_OFFERS = 7;
   localparam int IN_OFFERS  = 7;
   localparam int COUNT_W    = 3;

   localparam int REQ_TDATA_W = 248;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [2:0] {
      OP_RECEIVE  = 3'd0,
      OP_RESPOND  = 3'd1,
      OP_GET_SRC  = 3'd2,
      OP_REQUEST  = 3'd3,
      OP_SELECT   = 3'd4,
      OP_RESET_ID = 3'd5,
      OP_REEVAL   = 3'd6,
      OP_NOP      = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WRITE,
      ST_EVAL_RD,
      ST_EVAL_CHK,
      ST_REQ_RD,
      ST_REQ_BUILD,
      ST_FINISH
   } state_type;

   // Received message kinds: bit 4 marks a data message.
   localparam logic [4:0] KIND_GOODCRC      = 5'h01;
   localparam logic [4:0] KIND_PS_RDY       = 5'h06;
   localparam logic [4:0] KIND_GET_SINK_CAP = 5'h08;
   localparam logic [4:0] KIND_DR_SWAP      = 5'h09;
   localparam logic [4:0] KIND_PR_SWAP      = 5'h0A;
   localparam logic [4:0] KIND_VCONN_SWAP   = 5'h0B;
   localparam logic [4:0] KIND_SOFT_RESET   = 5'h0D;
   localparam logic [4:0] KIND_SRC_CAP      = 5'h11;
   localparam logic [4:0] KIND_DATA_BIT     = 5'h10;

   // Transmitted message types.
   localparam logic [3:0] TX_REQUEST     = 4'h2;
   localparam logic [3:0] TX_ACCEPT      = 4'h3;
   localparam logic [3:0] TX_REJECT      = 4'h4;
   localparam logic [3:0] TX_SINK_CAP    = 4'h4;
   localparam logic [3:0] TX_GET_SRC_CAP = 4'h7;

   // 5 V at 1 A, fixed supply, higher capability set.
   localparam logic [31:0] SINK_CAP_OBJECT = {3'b000, 1'b1, 1'b0, 1'b1, 6'b0,
                                              10'd100, 10'd100};

   typedef struct packed {
      logic [9:0] volt;
      logic [9:0] curr;
      logic [9:0] pwr;
   } offer_info_type;

   function automatic offer_info_type decode_offer(input logic [31:0] obj);
      offer_info_type info;
      info = '0;
      case (obj[31:30])
         2'd0: begin
            info.volt = obj[19:10];
            info.curr = obj[9:0];
         end
         2'd1: begin
            info.volt = obj[29:20];
            info.pwr  = obj[9:0];
         end
         2'd2: begin
            info.volt = obj[29:20];
            info.curr = obj[9:0];
         end
         default: info = '0;
      endcase
      return info;
   endfunction

   function automatic logic [13:0] score_limit(input logic [2:0] opt);
      logic [13:0] lim;
      case (opt)
         3'd0:    lim = 14'd25;
         3'd1:    lim = 14'd45;
         3'd2:    lim = 14'd60;
         3'd3:    lim = 14'd75;
         3'd4:    lim = 14'd100;
         3'd5:    lim = 14'd100;
         3'd6:    lim = 14'd125;
         default: lim = 14'd12500;
      endcase
      return lim;
   endfunction

   function automatic logic score_uses_volt(input logic [2:0] opt);
      return (opt != 3'd6);
   endfunction

   function automatic logic score_uses_curr(input logic [2:0] opt);
      return (opt == 3'd6) || (opt == 3'd7);
   endfunction

   function automatic logic [15:0] make_header(input logic [3:0] msg_type,
                                               input logic [2:0] count,
                                               input logic [2:0] msg_id);
      return {1'b0, count, msg_id, 2'b00, 1'b1, 2'b00, msg_type};
   endfunction

endpackage

// ----- rtl/usb_pd_sink_message_engine.sv -----
// ----------------------------------------------------------------------------
// USB PD sink message engine
// Sink-side protocol layer: decodes received headers, keeps the offer table
// and builds the answers and requests that the sink sends.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries one command in req_tuser and the
// received header, seven data objects and a select index in req_tdata. Every
// command returns exactly one transfer on the rsp_ channel with the message to
// send, the event flags and the current status.
// Simple commands pass from ST_EXEC through ST_FINISH to the result register. A
// Source_Capabilities message writes its objects into the table in ST_WRITE,
// then reads and scores each offer in ST_EVAL_RD and ST_EVAL_CHK; building a
// Request adds ST_REQ_RD and ST_REQ_BUILD. The offer table is a 7-entry
// single-port memory, and objects are written into it one per cycle.
// A new command is taken once the engine is idle; a finished result waits in
// the output register while the next command runs, and the engine holds its
// last step until that register is free when the receiver stalls.
// Synchronous reset clears the message ID, the last message kind, the offer
// count, the selected offer and the power option. The table needs no clearing.
// csr_wr_en writes the power option; only the user keeps it to an idle engine.
// ----------------------------------------------------------------------------
module usb_pd_sink_message_engine
   import usbpd_snk_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_wr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rx_header, offer_0 .. offer_6, select_index, zero padding
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tx_header, tx_object, event_ps_rdy, event_src_cap, command_ok,
   // selected_index, offer_count, next_message_id, zero padding
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // tx_valid, tx_has_object
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   state_type    state_ff, state_in;

   logic [2:0]   power_option_ff;
   logic [2:0]   msg_counter_ff, msg_counter_in;
   logic [4:0]   last_rx_kind_ff, last_rx_kind_in;
   logic [2:0]   stored_count_ff, stored_count_in;
   logic [2:0]   chosen_offer_ff, chosen_offer_in;
   logic [2:0]   idx_ff, idx_in;

   opcode_type   op_ff;
   logic [15:0]  hdr_ff;
   logic [31:0]  offer_in_ff [IN_OFFERS];
   logic [2:0]   sel_ff;

   logic         tx_valid_ff, tx_valid_in;
   logic [15:0]  tx_header_ff, tx_header_in;
   logic         tx_has_obj_ff, tx_has_obj_in;
   logic [31:0]  tx_object_ff, tx_object_in;
   logic         ev_rdy_ff, ev_rdy_in;
   logic         ev_cap_ff, ev_cap_in;
   logic         ok_ff, ok_in;

   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff;

   logic [31:0]  offer_mem [MAX_OFFERS];
   logic [31:0]  rd_data_ff;
   logic         mem_we;
   logic         mem_re;
   logic [2:0]   mem_raddr;

   logic         accept;
   logic         out_load;
   logic [4:0]   rx_kind;
   logic [2:0]   rx_count;
   logic [2:0]   rx_count_clamped;
   logic         respond_request;
   logic         eval_last;

   offer_info_type eval_info;
   offer_info_type req_info;
   logic [7:0]   fac_volt;
   logic [7:0]   fac_curr;
   logic [15:0]  score;
   logic [9:0]   req_curr;
   logic [2:0]   req_pos;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   assign rx_count         = hdr_ff[14:12];
   assign rx_kind          = (rx_count != 3'd0) ? (KIND_DATA_BIT | {1'b0, hdr_ff[3:0]})
                                                : {1'b0, hdr_ff[3:0]};
   assign rx_count_clamped = (rx_count > COUNT_W'(MAX_OFFERS)) ? COUNT_W'(MAX_OFFERS)
                                                               : rx_count;
   assign respond_request  = (last_rx_kind_ff == KIND_SRC_CAP);
   assign eval_last        = (idx_ff == (stored_count_ff - 3'd1));

   assign eval_info = decode_offer(rd_data_ff);
   assign fac_volt  = score_uses_volt(power_option_ff) ? eval_info.volt[9:2] : 8'd1;
   assign fac_curr  = score_uses_curr(power_option_ff) ? eval_info.curr[9:2] : 8'd1;
   assign score     = fac_volt * fac_curr;

   assign req_info = ((stored_count_ff != 3'd0) && (chosen_offer_ff < stored_count_ff))
                     ? decode_offer(rd_data_ff) : '0;
   assign req_curr = (req_info.curr != 10'd0) ? req_info.curr : req_info.pwr;
   assign req_pos  = chosen_offer_ff + 3'd1;

   assign mem_we    = (state_ff == ST_WRITE);
   assign mem_re    = (state_ff == ST_EVAL_RD) || (state_ff == ST_REQ_RD);
   assign mem_raddr = (state_ff == ST_REQ_RD) ? chosen_offer_ff : idx_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            case (op_ff)
               OP_RECEIVE: begin
                  if (rx_kind == KIND_SRC_CAP) begin
                     state_in = ST_WRITE;
                  end
               end
               OP_RESPOND: begin
                  if (respond_request) begin
                     state_in = ST_REQ_RD;
                  end
               end
               OP_REQUEST: state_in = ST_REQ_RD;
               OP_REEVAL: begin
                  if (stored_count_ff != 3'd0) begin
                     state_in = ST_EVAL_RD;
                  end
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_WRITE: begin
            if (eval_last) begin
               state_in = ST_EVAL_RD;
            end
         end
         ST_EVAL_RD:   state_in = ST_EVAL_CHK;
         ST_EVAL_CHK:  state_in = eval_last ? ST_FINISH : ST_EVAL_RD;
         ST_REQ_RD:    state_in = ST_REQ_BUILD;
         ST_REQ_BUILD: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      msg_counter_in  = msg_counter_ff;
      last_rx_kind_in = last_rx_kind_ff;
      stored_count_in = stored_count_ff;
      chosen_offer_in = chosen_offer_ff;
      idx_in          = idx_ff;
      tx_valid_in     = tx_valid_ff;
      tx_header_in    = tx_header_ff;
      tx_has_obj_in   = tx_has_obj_ff;
      tx_object_in    = tx_object_ff;
      ev_rdy_in       = ev_rdy_ff;
      ev_cap_in       = ev_cap_ff;
      ok_in           = ok_ff;
      case (state_ff)
         ST_EXEC: begin
            tx_valid_in   = 1'b0;
            tx_header_in  = '0;
            tx_has_obj_in = 1'b0;
            tx_object_in  = '0;
            ev_rdy_in     = 1'b0;
            ev_cap_in     = 1'b0;
            ok_in         = 1'b0;
            idx_in        = 3'd0;
            case (op_ff)
               OP_RECEIVE: begin
                  last_rx_kind_in = rx_kind;
                  if (rx_kind == KIND_GOODCRC) begin
                     msg_counter_in = msg_counter_ff + 3'd1;
                  end else if (rx_kind == KIND_PS_RDY) begin
                     ev_rdy_in = 1'b1;
                  end else if (rx_kind == KIND_SRC_CAP) begin
                     stored_count_in = rx_count_clamped;
                     chosen_offer_in = 3'd0;
                     ev_cap_in       = 1'b1;
                  end
               end
               OP_RESPOND: begin
                  case (last_rx_kind_ff)
                     KIND_GET_SINK_CAP: begin
                        tx_valid_in   = 1'b1;
                        tx_has_obj_in = 1'b1;
                        tx_object_in  = SINK_CAP_OBJECT;
                        tx_header_in  = make_header(TX_SINK_CAP, 3'd1, msg_counter_ff);
                     end
                     KIND_DR_SWAP, KIND_PR_SWAP, KIND_VCONN_SWAP: begin
                        tx_valid_in  = 1'b1;
                        tx_header_in = make_header(TX_REJECT, 3'd0, msg_counter_ff);
                     end
                     KIND_SOFT_RESET: begin
                        tx_valid_in  = 1'b1;
                        tx_header_in = make_header(TX_ACCEPT, 3'd0, msg_counter_ff);
                     end
                     KIND_SRC_CAP: begin
                        tx_valid_in   = 1'b1;
                        tx_has_obj_in = 1'b1;
                        tx_header_in  = make_header(TX_REQUEST, 3'd1, msg_counter_ff);
                     end
                     default: tx_valid_in = 1'b0;
                  endcase
               end
               OP_GET_SRC: begin
                  tx_valid_in  = 1'b1;
                  tx_header_in = make_header(TX_GET_SRC_CAP, 3'd0, msg_counter_ff);
               end
               OP_REQUEST: begin
                  tx_valid_in   = 1'b1;
                  tx_has_obj_in = 1'b1;
                  tx_header_in  = make_header(TX_REQUEST, 3'd1, msg_counter_ff);
               end
               OP_SELECT: begin
                  if (sel_ff < stored_count_ff) begin
                     chosen_offer_in = sel_ff;
                     ok_in           = 1'b1;
                  end
               end
               OP_RESET_ID: begin
                  msg_counter_in  = 3'd0;
                  last_rx_kind_in = 5'd0;
               end
               OP_REEVAL: begin
                  if (stored_count_ff != 3'd0) begin
                     chosen_offer_in = 3'd0;
                     ok_in           = 1'b1;
                  end
               end
               default: ok_in = 1'b0;
            endcase
         end
         ST_WRITE: begin
            idx_in = eval_last ? 3'd0 : idx_ff + 3'd1;
         end
         ST_EVAL_CHK: begin
            if (score <= {2'b00, score_limit(power_option_ff)}) begin
               chosen_offer_in = idx_ff;
            end
            idx_in = idx_ff + 3'd1;
         end
         ST_REQ_BUILD: begin
            tx_object_in = {1'b0, req_pos, 2'b00, 1'b1, 5'b0, req_curr, req_curr};
         end
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         power_option_ff <= 3'd0;
         msg_counter_ff  <= 3'd0;
         last_rx_kind_ff <= 5'd0;
         stored_count_ff <= 3'd0;
         chosen_offer_ff <= 3'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         msg_counter_ff  <= msg_counter_in;
         last_rx_kind_ff <= last_rx_kind_in;
         stored_count_ff <= stored_count_in;
         chosen_offer_ff <= chosen_offer_in;
         if (csr_wr_en) begin
            power_option_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      tx_valid_ff   <= tx_valid_in;
      tx_header_ff  <= tx_header_in;
      tx_has_obj_ff <= tx_has_obj_in;
      tx_object_ff  <= tx_object_in;
      ev_rdy_ff     <= ev_rdy_in;
      ev_cap_ff     <= ev_cap_in;
      ok_ff         <= ok_in;
      if (accept) begin
         op_ff  <= opcode_type'(req_tuser[2:0]);
         hdr_ff <= req_tdata[15:0];
         sel_ff <= req_tdata[242:240];
         for (int k = 0; k < IN_OFFERS; k++) begin
            offer_in_ff[k] <= req_tdata[16 + 32*k +: 32];
         end
      end
      if (out_load) begin
         rsp_tdata_ff <= {4'b0, msg_counter_ff, stored_count_ff, chosen_offer_ff,
                          ok_ff, ev_cap_ff, ev_rdy_ff, tx_object_ff, tx_header_ff};
         rsp_tuser_ff <= {tx_has_obj_ff, tx_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         offer_mem[idx_ff] <= offer_in_ff[idx_ff];
      end
      if (mem_re) begin
         rd_data_ff <= offer_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_chosen_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |->
         ((stored_count_ff == 3'd0) ? (chosen_offer_ff == 3'd0)
                                    : (chosen_offer_ff < stored_count_ff)))
      else $error("selected offer lies outside the offer table");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (idx_ff < stored_count_ff) && (stored_count_ff != 3'd0))
      else $error("offer write beyond the stored count");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC) && !req_tready)
      else $error("accepted transfer did not start a command");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_tready) |=>
         (state_ff == ST_FINISH) && $stable(rsp_tdata_ff))
      else $error("result overwrote a pending transfer");

endmodule

// ----- verif/usb_pd_sink_message_engine_tb.sv -----
// ----------------------------------------------------------------------------
// USB PD sink message engine testbench
// Sends commands on the req_ stream and checks every rsp_ transfer against a
// cycle-free sink protocol model or a table value. The run starts with a short
// table of directed commands, then sends random message sequences under all
// power policies, with random stalls on both sides and one phase without any.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module usb_pd_sink_message_engine_tb;
   import usbpd_snk_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int BLOCK_ITEMS    = 110;
   localparam int RANDOM_BLOCKS  = 15;

   localparam logic [1:0] PDO_FIXED    = 2'd0;
   localparam logic [1:0] PDO_BATTERY  = 2'd1;
   localparam logic [1:0] PDO_VARIABLE = 2'd2;

   localparam logic [2:0] POL_MAX_I = 3'd6;
   localparam logic [2:0] POL_MAX_P = 3'd7;

   localparam logic [4:0]  KIND_NONE    = 5'h00;
   localparam logic [31:0] SINK_PDO     = 32'd100 | (32'd100 << 10) | (32'd1 << 26) |
                                          (32'd1 << 28);
   localparam logic [31:0] REQ_FLAG_BIT = 32'd1 << 25;

   typedef logic [6:0][31:0] offer_set_t;

   typedef struct packed {
      logic        tx_valid;
      logic [15:0] tx_header;
      logic        tx_has_object;
      logic [31:0] tx_object;
      logic        ps_rdy;
      logic        src_cap;
      logic        cmd_ok;
      logic [2:0]  sel_idx;
      logic [2:0]  offer_cnt;
      logic [2:0]  msg_id;
   } rsp_fields_t;

   typedef struct packed {
      logic [9:0] volt;
      logic [9:0] amps;
      logic [9:0] watts;
   } pdo_terms_t;

   typedef struct packed {
      opcode_type  op;
      logic [15:0] hdr;
      offer_set_t  obj;
      logic [2:0]  sel;
      logic        use_row_rsp;
      rsp_fields_t row_rsp;
   } stim_row_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [2:0]             csr_wr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   logic [2:0]  pd_policy = '0;
   logic [2:0]  pd_msg_id = '0;
   logic [4:0]  pd_last_kind = KIND_NONE;
   logic [31:0] pd_offers [MAX_OFFERS];
   logic [2:0]  pd_count = '0;
   logic [2:0]  pd_chosen = '0;

   rsp_fields_t pending_rsp_q [$];
   stim_row_t   dir_rows [$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;

   usb_pd_sink_message_engine dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic pdo_terms_t pdo_terms(input logic [2:0] idx);
      pdo_terms_t  t;
      logic [31:0] w;
      t = '0;
      if (idx < pd_count) begin
         w = pd_offers[idx];
         case (w[31:30])
            PDO_FIXED: begin
               t.volt = w[19:10];
               t.amps = w[9:0];
            end
            PDO_BATTERY: begin
               t.volt  = w[29:20];
               t.watts = w[9:0];
            end
            PDO_VARIABLE: begin
               t.volt = w[29:20];
               t.amps = w[9:0];
            end
            default: t = '0;
         endcase
      end
      return t;
   endfunction

   function automatic void pick_offer();
      pdo_terms_t  t;
      int unsigned vf;
      int unsigned cf;
      int unsigned cap;
      logic [2:0]  best;
      best = '0;
      case (pd_policy)
         3'd0:    cap = 25;
         3'd1:    cap = 45;
         3'd2:    cap = 60;
         3'd3:    cap = 75;
         3'd4:    cap = 100;
         3'd5:    cap = 100;
         3'd6:    cap = 125;
         default: cap = 12500;
      endcase
      for (int n = 0; n < pd_count; n++) begin
         t  = pdo_terms(3'(n));
         vf = (pd_policy != POL_MAX_I) ? int'(t.volt >> 2) : 1;
         cf = (pd_policy == POL_MAX_I || pd_policy == POL_MAX_P) ? int'(t.amps >> 2) : 1;
         if (vf * cf <= cap)
            best = 3'(n);
      end
      pd_chosen = best;
   endfunction

   function automatic logic [15:0] pd_header(input logic [3:0] msg_type,
                                             input logic [2:0] cnt);
      return 16'(msg_type) | 16'h0040 | (16'(pd_msg_id) << 9) | (16'(cnt) << 12);
   endfunction

   function automatic logic [31:0] request_pdo();
      pdo_terms_t t;
      logic [9:0] amt;
      logic [2:0] pos;
      t   = pdo_terms(pd_chosen);
      amt = (t.amps != 0) ? t.amps : t.watts;
      pos = pd_chosen + 3'd1;
      return 32'(amt) | (32'(amt) << 10) | REQ_FLAG_BIT | (32'(pos) << 28);
   endfunction

   function automatic rsp_fields_t predict_response(input opcode_type op,
                                                    input logic [15:0] hdr,
                                                    input offer_set_t obj,
                                                    input logic [2:0] sel);
      rsp_fields_t r;
      logic [2:0]  cnt;
      r   = '0;
      cnt = hdr[14:12];
      case (op)
         OP_RECEIVE: begin
            pd_last_kind = (cnt != 3'd0) ? {1'b1, hdr[3:0]} : {1'b0, hdr[3:0]};
            if (pd_last_kind == KIND_GOODCRC) begin
               pd_msg_id = pd_msg_id + 3'd1;
            end else if (pd_last_kind == KIND_PS_RDY) begin
               r.ps_rdy = 1'b1;
            end else if (pd_last_kind == KIND_SRC_CAP) begin
               pd_count = (cnt > MAX_OFFERS) ? 3'(MAX_OFFERS) : cnt;
               for (int k = 0; k < pd_count; k++)
                  pd_offers[k] = obj[k];
               pick_offer();
               r.src_cap = 1'b1;
            end
         end
         OP_RESPOND: begin
            case (pd_last_kind)
               KIND_GET_SINK_CAP: begin
                  r.tx_valid      = 1'b1;
                  r.tx_has_object = 1'b1;
                  r.tx_object     = SINK_PDO;
                  r.tx_header     = pd_header(TX_SINK_CAP, 3'd1);
               end
               KIND_DR_SWAP, KIND_PR_SWAP, KIND_VCONN_SWAP: begin
                  r.tx_valid  = 1'b1;
                  r.tx_header = pd_header(TX_REJECT, 3'd0);
               end
               KIND_SOFT_RESET: begin
                  r.tx_valid  = 1'b1;
                  r.tx_header = pd_header(TX_ACCEPT, 3'd0);
               end
               KIND_SRC_CAP: begin
                  r.tx_valid      = 1'b1;
                  r.tx_has_object = 1'b1;
                  r.tx_object     = request_pdo();
                  r.tx_header     = pd_header(TX_REQUEST, 3'd1);
               end
               default: ;
            endcase
         end
         OP_GET_SRC: begin
            r.tx_valid  = 1'b1;
            r.tx_header = pd_header(TX_GET_SRC_CAP, 3'd0);
         end
         OP_REQUEST: begin
            r.tx_valid      = 1'b1;
            r.tx_has_object = 1'b1;
            r.tx_object     = request_pdo();
            r.tx_header     = pd_header(TX_REQUEST, 3'd1);
         end
         OP_SELECT: begin
            if (sel < pd_count) begin
               pd_chosen = sel;
               r.cmd_ok  = 1'b1;
            end
         end
         OP_RESET_ID: begin
            pd_msg_id    = '0;
            pd_last_kind = KIND_NONE;
         end
         OP_REEVAL: begin
            if (pd_count != 3'd0) begin
               pick_offer();
               r.cmd_ok = 1'b1;
            end
         end
         default: ;
      endcase
      r.sel_idx   = pd_chosen;
      r.offer_cnt = pd_count;
      r.msg_id    = pd_msg_id;
      return r;
   endfunction

   function automatic rsp_fields_t table_rsp(input logic tv, input logic [15:0] hdr,
                                             input logic ho, input logic [31:0] obj,
                                             input logic [2:0] sel, input logic [2:0] cnt,
                                             input logic [2:0] id, input logic rdy);
      rsp_fields_t r;
      r               = '0;
      r.tx_valid      = tv;
      r.tx_header     = hdr;
      r.tx_has_object = ho;
      r.tx_object     = obj;
      r.ps_rdy        = rdy;
      r.sel_idx       = sel;
      r.offer_cnt     = cnt;
      r.msg_id        = id;
      return r;
   endfunction

   function automatic void add_row(input opcode_type op, input logic [15:0] hdr,
                                   input offer_set_t obj, input logic [2:0] sel,
                                   input logic use_row_rsp, input rsp_fields_t row_rsp);
      stim_row_t row;
      row.op          = op;
      row.hdr         = hdr;
      row.obj         = obj;
      row.sel         = sel;
      row.use_row_rsp = use_row_rsp;
      row.row_rsp     = row_rsp;
      dir_rows.push_back(row);
   endfunction

   function automatic logic [31:0] rand_pdo();
      logic [31:0] w;
      logic [9:0]  v;
      w = $urandom;
      case ($urandom_range(0, 3))
         0:       v = 10'($urandom);
         1:       v = 10'(100 + $urandom_range(0, 8) - 4);
         2:       v = 10'(180 + $urandom_range(0, 140));
         default: v = 10'(240 + $urandom_range(0, 160));
      endcase
      case ($urandom_range(0, 9))
         0, 1: ;
         2, 3, 4, 5: begin
            w[31:30] = PDO_FIXED;
            w[19:10] = v;
         end
         6, 7: begin
            w[31:30] = PDO_VARIABLE;
            w[29:20] = v;
         end
         8: begin
            w[31:30] = PDO_BATTERY;
            w[29:20] = v;
         end
         default: w[31:30] = 2'd3;
      endcase
      if ($urandom_range(0, 1) == 0)
         w[9:0] = 10'($urandom_range(0, 520));
      return w;
   endfunction

   task automatic send_item(input opcode_type op, input logic [15:0] hdr,
                            input offer_set_t obj, input logic [2:0] sel,
                            input logic use_row_rsp, input rsp_fields_t row_rsp);
      int          gap;
      rsp_fields_t predicted;
      gap = 0;
      while ($urandom_range(0, 99) < req_idle_pct && gap < 40)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, sel, obj, hdr};
      do @(posedge clock); while (!req_tready);
      predicted = predict_response(op, hdr, obj, sel);
      pending_rsp_q.push_back(use_row_rsp ? row_rsp : predicted);
   endtask

   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_policy(input logic [2:0] value);
      drain(4);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pd_policy   = value;
   endtask

   task automatic run_random(input int n_items);
      int          done;
      int          r;
      offer_set_t  obj;
      logic [15:0] hdr;
      logic [2:0]  sel;
      done = 0;
      while (done < n_items) begin
         for (int k = 0; k < MAX_OFFERS; k++)
            obj[k] = rand_pdo();
         hdr = 16'($urandom);
         sel = 3'($urandom);
         r   = $urandom_range(0, 99);
         if (r < 35) begin
            hdr[3:0]   = KIND_SRC_CAP[3:0];
            hdr[14:12] = 3'($urandom_range(1, MAX_OFFERS));
            send_item(OP_RECEIVE, hdr, obj, sel, 1'b0, '0);
            done++;
            if ($urandom_range(0, 9) < 7) begin
               send_item(OP_RESPOND, 16'($urandom), obj, sel, 1'b0, '0);
               done++;
            end
         end else if (r < 50) begin
            case ($urandom_range(0, 6))
               0:       hdr[3:0] = KIND_GOODCRC[3:0];
               1:       hdr[3:0] = KIND_PS_RDY[3:0];
               2:       hdr[3:0] = KIND_GET_SINK_CAP[3:0];
               3:       hdr[3:0] = KIND_DR_SWAP[3:0];
               4:       hdr[3:0] = KIND_PR_SWAP[3:0];
               5:       hdr[3:0] = KIND_VCONN_SWAP[3:0];
               default: hdr[3:0] = KIND_SOFT_RESET[3:0];
            endcase
            hdr[14:12] = 3'd0;
            send_item(OP_RECEIVE, hdr, obj, sel, 1'b0, '0);
            done++;
            if ($urandom_range(0, 9) < 6) begin
               send_item(OP_RESPOND, 16'($urandom), obj, sel, 1'b0, '0);
               done++;
            end
         end else if (r < 58) begin
            send_item(OP_RECEIVE, hdr, obj, sel, 1'b0, '0);
            done++;
         end else if (r < 66) begin
            send_item(OP_SELECT, hdr, obj, sel, 1'b0, '0);
            done++;
         end else if (r < 72) begin
            send_item(OP_REEVAL, hdr, obj, sel, 1'b0, '0);
            done++;
         end else if (r < 80) begin
            send_item(OP_REQUEST, hdr, obj, sel, 1'b0, '0);
            done++;
         end else if (r < 84) begin
            send_item(OP_GET_SRC, hdr, obj, sel, 1'b0, '0);
            done++;
         end else if (r < 88) begin
            send_item(OP_RESPOND, hdr, obj, sel, 1'b0, '0);
            done++;
         end else if (r < 91) begin
            send_item(OP_RESET_ID, hdr, obj, sel, 1'b0, '0);
            done++;
         end else if (r < 93) begin
            send_item(OP_NOP, hdr, obj, sel, 1'b0, '0);
         end else if (r < 94) begin
            drain(0);
         end else begin
            hdr[3:0]   = KIND_GOODCRC[3:0];
            hdr[14:12] = 3'd0;
            send_item(OP_RECEIVE, hdr, obj, sel, 1'b0, '0);
            done++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_fields_t got;
      rsp_fields_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.tx_valid      = rsp_tuser[0];
            got.tx_has_object = rsp_tuser[1];
            got.tx_header     = rsp_tdata[15:0];
            got.tx_object     = rsp_tdata[47:16];
            got.ps_rdy        = rsp_tdata[48];
            got.src_cap       = rsp_tdata[49];
            got.cmd_ok        = rsp_tdata[50];
            got.sel_idx       = rsp_tdata[53:51];
            got.offer_cnt     = rsp_tdata[56:54];
            got.msg_id        = rsp_tdata[59:57];
            if (pending_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: response transfer with nothing pending, tuser=%h tdata=%h",
                           rsp_tuser, rsp_tdata);
            end else begin
               want = pending_rsp_q.pop_front();
               if (got.tx_valid !== want.tx_valid || got.tx_header !== want.tx_header ||
                   got.tx_has_object !== want.tx_has_object ||
                   got.tx_object !== want.tx_object || got.ps_rdy !== want.ps_rdy ||
                   got.src_cap !== want.src_cap || got.cmd_ok !== want.cmd_ok ||
                   got.sel_idx !== want.sel_idx || got.offer_cnt !== want.offer_cnt ||
                   got.msg_id !== want.msg_id) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"ERROR: response mismatch, expected ",
                               "v=%b hdr=%h o=%b obj=%h rdy=%b cap=%b ok=%b sel=%0d cnt=%0d ",
                               "id=%0d, actual v=%b hdr=%h o=%b obj=%h rdy=%b cap=%b ok=%b ",
                               "sel=%0d cnt=%0d id=%0d"},
                              want.tx_valid, want.tx_header, want.tx_has_object,
                              want.tx_object, want.ps_rdy, want.src_cap, want.cmd_ok,
                              want.sel_idx, want.offer_cnt, want.msg_id,
                              got.tx_valid, got.tx_header, got.tx_has_object,
                              got.tx_object, got.ps_rdy, got.src_cap, got.cmd_ok,
                              got.sel_idx, got.offer_cnt, got.msg_id);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      offer_set_t cap_set;
      offer_set_t rnd_set;
      stim_row_t  row;
      int         mode;

      cap_set[0] = 32'h0001_912C;
      cap_set[1] = 32'h0002_D064;
      cap_set[2] = 32'hFFFF_FFFF;
      cap_set[3] = 32'h45A0_03FF;
      cap_set[4] = 32'hBFF0_03FF;
      cap_set[5] = 32'h0000_0000;
      cap_set[6] = 32'h7FFF_FFFF;
      rnd_set    = cap_set;
      rnd_set[0] = 32'hFFFF_FFFF;

      add_row(OP_RESPOND, 16'h0000, '0, 3'd0, 1'b1,
              table_rsp(1'b0, 16'h0000, 1'b0, 32'h0, 3'd0, 3'd0, 3'd0, 1'b0));
      add_row(OP_GET_SRC, 16'h0000, '0, 3'd0, 1'b1,
              table_rsp(1'b1, 16'h0047, 1'b0, 32'h0, 3'd0, 3'd0, 3'd0, 1'b0));
      add_row(OP_REQUEST, 16'h0000, '0, 3'd0, 1'b1,
              table_rsp(1'b1, 16'h1042, 1'b1, 32'h1200_0000, 3'd0, 3'd0, 3'd0, 1'b0));
      add_row(OP_REEVAL, 16'hFFFF, '1, 3'd7, 1'b1,
              table_rsp(1'b0, 16'h0000, 1'b0, 32'h0, 3'd0, 3'd0, 3'd0, 1'b0));
      add_row(OP_SELECT, 16'h0000, '0, 3'd7, 1'b1,
              table_rsp(1'b0, 16'h0000, 1'b0, 32'h0, 3'd0, 3'd0, 3'd0, 1'b0));
      add_row(OP_RECEIVE, 16'h0001, '0, 3'd0, 1'b1,
              table_rsp(1'b0, 16'h0000, 1'b0, 32'h0, 3'd0, 3'd0, 3'd1, 1'b0));
      add_row(OP_RECEIVE, 16'h0006, '0, 3'd0, 1'b1,
              table_rsp(1'b0, 16'h0000, 1'b0, 32'h0, 3'd0, 3'd0, 3'd1, 1'b1));
      add_row(OP_RECEIVE, 16'h0008, '0, 3'd0, 1'b0, '0);
      add_row(OP_RESPOND, 16'h0000, '0, 3'd0, 1'b0, '0);
      add_row(OP_RECEIVE, 16'h0009, '0, 3'd0, 1'b0, '0);
      add_row(OP_RESPOND, 16'h0000, '0, 3'd0, 1'b0, '0);
      add_row(OP_RECEIVE, 16'h800A, '0, 3'd0, 1'b0, '0);
      add_row(OP_RESPOND, 16'h0000, '0, 3'd0, 1'b0, '0);
      add_row(OP_RECEIVE, 16'h0FFB, '0, 3'd0, 1'b0, '0);
      add_row(OP_RESPOND, 16'h0000, '0, 3'd0, 1'b0, '0);
      add_row(OP_RECEIVE, 16'h000D, '0, 3'd0, 1'b0, '0);
      add_row(OP_RESPOND, 16'h0000, '0, 3'd0, 1'b0, '0);
      add_row(OP_RECEIVE, 16'h7001, cap_set, 3'd0, 1'b0, '0);
      add_row(OP_RESPOND, 16'h0000, '0, 3'd0, 1'b0, '0);
      add_row(OP_SELECT, 16'h0000, '0, 3'd7, 1'b0, '0);
      add_row(OP_SELECT, 16'h0000, '0, 3'd3, 1'b0, '0);
      add_row(OP_REQUEST, 16'h0000, '0, 3'd0, 1'b0, '0);
      add_row(OP_REEVAL, 16'h0000, '0, 3'd0, 1'b0, '0);
      add_row(OP_RECEIVE, 16'hFFFF, '1, 3'd7, 1'b0, '0);
      add_row(OP_RESPOND, 16'h0000, '0, 3'd0, 1'b0, '0);
      add_row(OP_RESET_ID, 16'h0000, '0, 3'd0, 1'b0, '0);
      add_row(OP_NOP, 16'hFFFF, '1, 3'd7, 1'b0, '0);
      add_row(OP_RECEIVE, 16'h1001, rnd_set, 3'd0, 1'b0, '0);
      add_row(OP_REQUEST, 16'h0000, '0, 3'd0, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 32;
      rsp_idle_pct = 52;

      foreach (dir_rows[n]) begin
         row = dir_rows[n];
         send_item(row.op, row.hdr, row.obj, row.sel, row.use_row_rsp, row.row_rsp);
      end

      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         mode = blk / 5;
         req_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 52 : 0;
         rsp_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 32 : 0;
         write_policy((blk < 8) ? 3'(blk) : 3'($urandom_range(0, 7)));
         run_random(BLOCK_ITEMS);
      end

      drain(SETTLE_CYCLES);
      if (fail_count == 0 && pending_rsp_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
